// ===== rtl/rgb_to_hsi_color_threshold_assert.svh =====
// Assertion macros for the HSI threshold block.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef RGB_TO_HSI_COLOR_THRESHOLD_ASSERT_SVH
`define RGB_TO_HSI_COLOR_THRESHOLD_ASSERT_SVH
`ifndef SYNTHESIS
`define RHCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhct check failed");
`define RHCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhct check failed");
`else
`define RHCT_ASSERT_NOW(lbl, ante, cons)
`define RHCT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rhct_pkg.sv =====
// Shared types, constants and the arctangent table for the HSI block.
// No dependencies.
package rhct_pkg;
  localparam int ITER_DEF = 16;
  localparam int ITER_MAX = 24;
  localparam int CW       = 27;  // CORDIC x/y width, signed
  localparam int ZW       = 18;  // angle accumulator, signed Q14
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 9;

  localparam logic [CFG_IW-1:0] REG_HUE_MIN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HUE_MAX = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SAT_MIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SAT_MAX = 3'd3;
  localparam logic [CFG_IW-1:0] REG_INT_MIN = 3'd4;
  localparam logic [CFG_IW-1:0] REG_INT_MAX = 3'd5;

  localparam logic [8:0]    HUE_MIN_RST = 9'd272;
  localparam logic [8:0]    HUE_MAX_RST = 9'd360;
  localparam logic [7:0]    SAT_MIN_RST = 8'd52;
  localparam logic [7:0]    SAT_MAX_RST = 8'd255;
  localparam logic [7:0]    INT_MIN_RST = 8'd25;
  localparam logic [7:0]    INT_MAX_RST = 8'd255;

  localparam logic [14:0]   SQRT3_Q14   = 15'd28378;
  localparam logic [ZW-1:0] HALF_PI_Q14 = 18'd25736;
  localparam logic [15:0]   PI_Q14      = 16'd51472;
  localparam logic [14:0]   HUE_SCALE   = 15'd25500;    // 255 * 100
  localparam logic [30:0]   FULL_M1     = 31'd10289151; // 628 * 2^14 - 1
  localparam logic [14:0]   RECIP_157   = 15'd26716;    // ceil(2^22 / 157)

  typedef struct packed {
    logic gray;
    logic bgt;   // blue above green: hue taken from the far side of the circle
  } hue_tag_t;

  function automatic logic [13:0] atan_q14(input logic [4:0] i);
    logic [13:0] v;
    case (i)
      5'd0:    v = 14'd12868;
      5'd1:    v = 14'd7596;
      5'd2:    v = 14'd4014;
      5'd3:    v = 14'd2037;
      5'd4:    v = 14'd1023;
      5'd5:    v = 14'd512;
      5'd6:    v = 14'd256;
      5'd7:    v = 14'd128;
      5'd8:    v = 14'd64;
      5'd9:    v = 14'd32;
      5'd10:   v = 14'd16;
      5'd11:   v = 14'd8;
      5'd12:   v = 14'd4;
      5'd13:   v = 14'd2;
      5'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction
endpackage

// ===== rtl/rhct_cordic.sv =====
// Vectoring CORDIC, one register stage per iteration.
// Depends on rhct_pkg.
module rhct_cordic #(
  parameter int ITER = rhct_pkg::ITER_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rhct_pkg::CW-1:0] x_in,
  input  logic signed [rhct_pkg::CW-1:0] y_in,
  input  logic signed [rhct_pkg::ZW-1:0] z_in,
  input  rhct_pkg::hue_tag_t             tag_in,
  output logic signed [rhct_pkg::ZW-1:0] z_out,
  output rhct_pkg::hue_tag_t             tag_out
);
  import rhct_pkg::*;

  logic signed [CW-1:0] x_r   [ITER];
  logic signed [CW-1:0] y_r   [ITER];
  logic signed [ZW-1:0] z_r   [ITER];
  hue_tag_t             tag_r [ITER];

  for (genvar s = 0; s < ITER; s++) begin : g_stage
    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] zs, z_nxt, da;
    hue_tag_t             ts;
    if (s == 0) begin : g_src0
      assign xs = x_in;
      assign ys = y_in;
      assign zs = z_in;
      assign ts = tag_in;
    end else begin : g_srcn
      assign xs = x_r[s-1];
      assign ys = y_r[s-1];
      assign zs = z_r[s-1];
      assign ts = tag_r[s-1];
    end
    assign da = $signed({{(ZW-14){1'b0}}, atan_q14(5'(s))});
    always_comb begin
      if (!ys[CW-1]) begin
        x_nxt = xs + (ys >>> s);
        y_nxt = ys - (xs >>> s);
        z_nxt = zs + da;
      end else begin
        x_nxt = xs - (ys >>> s);
        y_nxt = ys + (xs >>> s);
        z_nxt = zs - da;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]   <= x_nxt;
        y_r[s]   <= y_nxt;
        z_r[s]   <= z_nxt;
        tag_r[s] <= ts;
      end
    end
  end

  assign z_out   = z_r[ITER-1];
  assign tag_out = tag_r[ITER-1];
endmodule

// ===== rtl/rhct_satdiv.sv =====
// Pipelined restoring divider for saturation, one quotient bit a stage,
// padded to DEPTH stages so it lines up with the CORDIC. Depends on rhct_pkg.
module rhct_satdiv #(
  parameter int DEPTH = rhct_pkg::ITER_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] num_in,
  input  logic [9:0]  den_in,
  input  logic [7:0]  side_in,
  output logic [7:0]  quo_out,
  output logic [7:0]  side_out
);
  import rhct_pkg::*;

  logic [17:0] rem_r  [DEPTH];
  logic [9:0]  den_r  [DEPTH];
  logic [7:0]  quo_r  [DEPTH];
  logic [7:0]  side_r [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    logic [17:0] rs, rem_nxt;
    logic [9:0]  ds;
    logic [7:0]  qs, sd, quo_nxt;
    if (s == 0) begin : g_src0
      assign rs = num_in;
      assign ds = den_in;
      assign qs = 8'd0;
      assign sd = side_in;
    end else begin : g_srcn
      assign rs = rem_r[s-1];
      assign ds = den_r[s-1];
      assign qs = quo_r[s-1];
      assign sd = side_r[s-1];
    end
    if (s < 8) begin : g_div
      logic [17:0] trial;
      assign trial = 18'(ds) << (7 - s);
      always_comb begin
        rem_nxt = rs;
        quo_nxt = qs;
        if (rs >= trial) begin
          rem_nxt         = rs - trial;
          quo_nxt[7 - s]  = 1'b1;
        end
      end
    end else begin : g_hold
      assign rem_nxt = rs;
      assign quo_nxt = qs;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= ds;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= sd;
      end
    end
  end

  assign quo_out  = quo_r[DEPTH-1];
  assign side_out = side_r[DEPTH-1];
endmodule

// ===== rtl/rhct_hue.sv =====
// Angle to hue byte: clamp, scale by 255/6.28 through two constant
// multiplies, fold for the far half. Three stages. Depends on rhct_pkg.
module rhct_hue (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rhct_pkg::ZW-1:0] z_in,
  input  rhct_pkg::hue_tag_t             tag_in,
  input  logic [15:0]                   side_in,
  output logic [7:0]                    hue_out,
  output logic [15:0]                   side_out
);
  import rhct_pkg::*;

  logic [15:0] zc;
  logic [30:0] a_nxt, a_r;
  logic [29:0] p_r;
  hue_tag_t    t1_r, t2_r;
  logic [15:0] s1_r, s2_r, s3_r;
  logic [7:0]  c, hue_r, hue_nxt;

  always_comb begin
    if (z_in[ZW-1])
      zc = 16'd0;
    else if (z_in > $signed({2'b00, PI_Q14}))
      zc = PI_Q14;
    else
      zc = z_in[15:0];
    // far half needs the ceiling, so bias by full scale minus one
    a_nxt = 31'(zc) * 31'(HUE_SCALE) + (tag_in.bgt ? FULL_M1 : 31'd0);
  end

  assign c = p_r[29:22];
  always_comb begin
    if (t2_r.gray)
      hue_nxt = 8'd0;
    else if (t2_r.bgt)
      hue_nxt = 8'd255 - c;
    else
      hue_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      t1_r  <= tag_in;
      s1_r  <= side_in;
      p_r   <= 30'(a_r[30:16]) * 30'(RECIP_157);  // /2^14 /4, then /157
      t2_r  <= t1_r;
      s2_r  <= s1_r;
      hue_r <= hue_nxt;
      s3_r  <= s2_r;
    end
  end

  assign hue_out  = hue_r;
  assign side_out = s3_r;
endmodule

// ===== rtl/rgb_to_hsi_color_threshold.sv =====
// RGB to HSI converter with hue/saturation/intensity window mask.
// Stages: input stage, one stage per CORDIC iteration, three hue scaling stages,
// output register; one pixel per clock while the output is not stalled.
// Whole pipeline advances together; it holds while a result waits untaken.
// Synchronous active-low reset clears valid bits and loads register defaults.
`include "rgb_to_hsi_color_threshold_assert.svh"
module rgb_to_hsi_color_threshold #(
  parameter int ANGLE_ITERATIONS = rhct_pkg::ITER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // blue, green, red
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // hue, saturation, intensity
  output logic                         out_tuser,  // in_window
  input  logic                         cfg_we,
  input  logic [rhct_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rhct_pkg::CFG_DW-1:0]  cfg_wdata
);
  import rhct_pkg::*;

  localparam int ITER = (ANGLE_ITERATIONS > ITER_MAX) ? ITER_MAX : ANGLE_ITERATIONS;
  localparam int NV   = ITER + 4;  // valid bits up to the hue output

  logic [8:0] hue_min_r, hue_max_r;
  logic [7:0] sat_min_r, sat_max_r, int_min_r, int_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_min_r <= HUE_MIN_RST;
      hue_max_r <= HUE_MAX_RST;
      sat_min_r <= SAT_MIN_RST;
      sat_max_r <= SAT_MAX_RST;
      int_min_r <= INT_MIN_RST;
      int_max_r <= INT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_MIN: hue_min_r <= cfg_wdata;
        REG_HUE_MAX: hue_max_r <= cfg_wdata;
        REG_SAT_MIN: sat_min_r <= cfg_wdata[7:0];
        REG_SAT_MAX: sat_max_r <= cfg_wdata[7:0];
        REG_INT_MIN: int_min_r <= cfg_wdata[7:0];
        REG_INT_MAX: int_max_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic pipe_en;
  logic [NV-1:0] vld_r;
  logic out_tvalid_r;
  assign pipe_en   = !out_tvalid_r || out_tready;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r        <= {vld_r[NV-2:0], in_tvalid};
      out_tvalid_r <= vld_r[NV-1];
    end
  end

  // input stage
  logic [7:0] b, g, r, mn, ad;
  logic [9:0] sum;
  logic signed [10:0] d;
  logic signed [CW-1:0] x0, y0, xp_nxt, yp_nxt;
  logic signed [ZW-1:0] zp_nxt;
  logic [17:0] num_nxt;
  logic [9:0]  den_nxt;
  logic [20:0] i_prod;
  hue_tag_t    tag_nxt;

  assign b = in_tdata[7:0];
  assign g = in_tdata[15:8];
  assign r = in_tdata[23:16];

  always_comb begin
    sum = 10'(b) + 10'(g) + 10'(r);
    mn  = (g < b) ? g : b;
    mn  = (r < mn) ? r : mn;
    ad  = (g >= b) ? (g - b) : (b - g);
    d   = $signed({2'b00, r, 1'b0}) - $signed({3'b000, g}) - $signed({3'b000, b});
    x0  = CW'($signed({d, 14'd0}));
    y0  = $signed(CW'(ad) * CW'(SQRT3_Q14));
    if (x0[CW-1]) begin
      xp_nxt = y0;
      yp_nxt = -x0;
      zp_nxt = $signed(HALF_PI_Q14);
    end else begin
      xp_nxt = x0;
      yp_nxt = y0;
      zp_nxt = '0;
    end
    tag_nxt.gray = (r == g) && (g == b);
    tag_nxt.bgt  = b > g;
    if (sum == 10'd0) begin
      num_nxt = 18'd0;
      den_nxt = 10'd1;
    end else begin
      num_nxt = 18'(sum - 10'(3 * mn)) * 18'(8'd255);
      den_nxt = sum;
    end
    i_prod = 21'(sum) * 21'(11'd683);  // floor(s/3) = floor(s*683/2^11) for s < 2048
  end

  logic signed [CW-1:0] xp_r, yp_r;
  logic signed [ZW-1:0] zp_r;
  hue_tag_t    tagp_r;
  logic [17:0] nump_r;
  logic [9:0]  denp_r;
  logic [7:0]  intp_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      xp_r   <= xp_nxt;
      yp_r   <= yp_nxt;
      zp_r   <= zp_nxt;
      tagp_r <= tag_nxt;
      nump_r <= num_nxt;
      denp_r <= den_nxt;
      intp_r <= i_prod[18:11];
    end
  end

  logic signed [ZW-1:0] zc;
  hue_tag_t tagc;
  logic [7:0] sat_c, int_c, hue_h;
  logic [15:0] side_h;

  rhct_cordic #(.ITER(ITER)) u_cordic (
    .clk(clk), .en(pipe_en), .x_in(xp_r), .y_in(yp_r), .z_in(zp_r),
    .tag_in(tagp_r), .z_out(zc), .tag_out(tagc)
  );

  rhct_satdiv #(.DEPTH(ITER)) u_satdiv (
    .clk(clk), .en(pipe_en), .num_in(nump_r), .den_in(denp_r),
    .side_in(intp_r), .quo_out(sat_c), .side_out(int_c)
  );

  rhct_hue u_hue (
    .clk(clk), .en(pipe_en), .z_in(zc), .tag_in(tagc),
    .side_in({int_c, sat_c}), .hue_out(hue_h), .side_out(side_h)
  );

  logic [16:0] hue_deg;
  logic win_nxt;
  logic [23:0] out_tdata_r;
  logic out_tuser_r;

  always_comb begin
    hue_deg = 17'(hue_h) * 17'(9'd360);
    win_nxt = (hue_deg <= 17'(hue_max_r) * 17'(8'd255))
           && (hue_deg >= 17'(hue_min_r) * 17'(8'd255))
           && (side_h[7:0] <= sat_max_r) && (side_h[7:0] >= sat_min_r)
           && (side_h[15:8] <= int_max_r) && (side_h[15:8] >= int_min_r);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata_r <= {side_h[15:8], side_h[7:0], hue_h};
      out_tuser_r <= win_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `RHCT_ASSERT_NOW(a_ready_follows_out, 1'b1, in_tready == (!out_tvalid || out_tready))
  `RHCT_ASSERT_NXT(a_hold_on_stall, !pipe_en, $stable(vld_r) && $stable(out_tdata))
  `RHCT_ASSERT_NOW(a_mask_sat, out_tvalid && out_tuser && $stable(sat_min_r) &&
    $stable(sat_max_r), out_tdata[15:8] >= sat_min_r && out_tdata[15:8] <= sat_max_r)
endmodule

// ===== tb/tb_rgb_to_hsi_color_threshold.sv =====
// Self-checking bench for rgb_to_hsi_color_threshold: directed table, then random pixels,
// checked against table values or an HSI predictor with CORDIC hue. Depends on rhct_pkg.
`timescale 1ns / 100ps
module tb_rgb_to_hsi_color_threshold;
  import rhct_pkg::*;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] inten;
    logic       win;
  } hsi_t;

  typedef struct {
    logic [7:0] b, g, r;
    logic       fixed;
    hsi_t       want;
  } pixel_row_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [23:0] in_tdata, out_tdata;
  logic        cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  rgb_to_hsi_color_threshold uut (.*);

  int unsigned win_hue_lo, win_hue_hi, win_sat_lo, win_sat_hi, win_int_lo, win_int_hi;
  hsi_t hsi_pending[$];
  int   errors;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int unsigned cordic_hue(int b, int g, int r);
    longint x, y, z, t, dx, dy, full;
    x = longint'(2*r - g - b) * 16384;
    y = longint'(g >= b ? g - b : b - g) * 28378;
    z = 0;
    full = 628 * 16384;
    if (r == g && g == b) return 0;
    if (x < 0) begin
      t = x; x = y; y = -t; z = 25736;
    end
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q14(i[4:0]);
      end else begin
        x -= dx; y += dy; z -= atan_q14(i[4:0]);
      end
    end
    if (z < 0) z = 0;
    if (z > 51472) z = 51472;
    if (b <= g) return int'((25500 * z) / full);
    return int'((255 * full - 25500 * z) / full);
  endfunction

  function automatic hsi_t predict_hsi(int b, int g, int r);
    hsi_t o;
    int s, mn, h, sa, it;
    s = b + g + r;
    mn = b < g ? b : g;
    mn = r < mn ? r : mn;
    h = cordic_hue(b, g, r);
    sa = (s == 0) ? 0 : (255 * (s - 3*mn)) / s;
    it = s / 3;
    o.hue = h[7:0]; o.sat = sa[7:0]; o.inten = it[7:0];
    o.win = (360*h <= 255*win_hue_hi) && (360*h >= 255*win_hue_lo) &&
            sa <= win_sat_hi && sa >= win_sat_lo && it <= win_int_hi && it >= win_int_lo;
    return o;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val[CFG_DW-1:0];
    case (idx)
      REG_HUE_MIN: win_hue_lo = val & 9'h1FF;
      REG_HUE_MAX: win_hue_hi = val & 9'h1FF;
      REG_SAT_MIN: win_sat_lo = val & 8'hFF;
      REG_SAT_MAX: win_sat_hi = val & 8'hFF;
      REG_INT_MIN: win_int_lo = val & 8'hFF;
      REG_INT_MAX: win_int_hi = val & 8'hFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_windows(int unsigned hl, hh, sl, sh, il, ih);
    write_reg(REG_HUE_MIN, hl); write_reg(REG_HUE_MAX, hh);
    write_reg(REG_SAT_MIN, sl); write_reg(REG_SAT_MAX, sh);
    write_reg(REG_INT_MIN, il); write_reg(REG_INT_MAX, ih);
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request; the expectation is queued at the accepting edge
  task automatic send_pixel(logic [7:0] b, g, r, bit fixed, hsi_t want, bit idle);
    int unsigned n;
    n = idle ? gap_len() : 0;
    if (n != 0) begin
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {r, g, b};
    do @(posedge clk); while (!in_tready);
    hsi_pending.insert(hsi_pending.size(), fixed ? want : predict_hsi(b, g, r));
  endtask

  task automatic drain();
    while (hsi_pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // receiver with random stalls, some bursts of steady ready
  initial begin
    int unsigned run;
    out_tready = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        hsi_t got, w;
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser};
        if (hsi_pending.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          w = hsi_pending.pop_front();
          if (got.hue !== w.hue) begin
            $error("hue exp %0d got %0d", w.hue, got.hue); errors++;
          end
          if (got.sat !== w.sat) begin
            $error("saturation exp %0d got %0d", w.sat, got.sat); errors++;
          end
          if (got.inten !== w.inten) begin
            $error("intensity exp %0d got %0d", w.inten, got.inten); errors++;
          end
          if (got.win !== w.win) begin
            $error("in_window exp %0d got %0d", w.win, got.win); errors++;
          end
        end
      end
      if (run != 0) begin
        run--;
        out_tready <= 1;
      end else if ($urandom_range(0, 19) == 0) begin
        run = $urandom_range(20, 80);
        out_tready <= 1;
      end else begin
        out_tready <= (gap_len() == 0);
      end
    end
  end

  pixel_row_t dir_rows[$];

  function automatic pixel_row_t mk(logic [7:0] b, g, r);
    pixel_row_t p;
    p.b = b; p.g = g; p.r = r; p.fixed = 0; p.want = '0;
    return p;
  endfunction

  function automatic pixel_row_t mkf(logic [7:0] b, g, r, hsi_t w);
    pixel_row_t p;
    p = mk(b, g, r); p.fixed = 1; p.want = w;
    return p;
  endfunction

  function automatic void add_row(pixel_row_t p);
    dir_rows.insert(dir_rows.size(), p);
  endfunction

  initial begin
    int unsigned b, g, r, m;
    errors = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    win_hue_lo = HUE_MIN_RST; win_hue_hi = HUE_MAX_RST;
    win_sat_lo = SAT_MIN_RST; win_sat_hi = SAT_MAX_RST;
    win_int_lo = INT_MIN_RST; win_int_hi = INT_MAX_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // black, white and gray pixels; pure primaries and secondaries; one-LSB and mixed colours
    add_row(mkf(0, 0, 0, '{8'd0, 8'd0, 8'd0, 1'b0}));
    add_row(mkf(255, 255, 255, '{8'd0, 8'd0, 8'd255, 1'b0}));
    add_row(mkf(128, 128, 128, '{8'd0, 8'd0, 8'd128, 1'b0}));
    add_row(mk(0, 0, 255));
    add_row(mk(0, 255, 0));
    add_row(mk(255, 0, 0));
    add_row(mk(0, 255, 255));
    add_row(mk(255, 0, 255));
    add_row(mk(255, 255, 0));
    add_row(mk(1, 0, 0));
    add_row(mk(0, 1, 0));
    add_row(mk(0, 0, 1));
    add_row(mk(200, 10, 250));
    add_row(mk(10, 200, 250));
    add_row(mk(254, 255, 0));
    add_row(mk(255, 254, 0));
    add_row(mk(170, 85, 255));
    add_row(mk(85, 170, 0));
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].b, dir_rows[i].g, dir_rows[i].r,
                 dir_rows[i].fixed, dir_rows[i].want, 0);
    in_tvalid <= 0;
    drain();

    // window settings: reset, wide open, empty (min above max), hue max 511, above 360, random
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: set_windows(0, 360, 0, 255, 0, 255);
        2: set_windows(360, 0, 255, 0, 255, 0);
        3: set_windows(0, 511, 0, 255, 0, 255);
        4: set_windows(400, 511, 0, 255, 0, 255);
        default: begin
          set_windows($urandom_range(0, 200), $urandom_range(150, 360),
                      $urandom_range(0, 100), $urandom_range(100, 255),
                      $urandom_range(0, 100), $urandom_range(100, 255));
          // index beyond the register list must be ignored
          write_reg(3'd7, $urandom_range(0, 511));
        end
      endcase
      for (int k = 0; k < 207; k++) begin
        m = $urandom_range(0, 9);
        b = $urandom_range(0, 255); g = $urandom_range(0, 255); r = $urandom_range(0, 255);
        if (m == 0) begin
          g = b; r = b;
        end else if (m == 1) begin
          g = b;
        end else if (m == 2) begin
          g = (b + $urandom_range(0, 4)) & 8'hFF;
        end
        send_pixel(b[7:0], g[7:0], r[7:0], 0, '0, 1);
      end
      in_tvalid <= 0;
      drain();
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== rgb_to_hsi_color_threshold.f =====
+incdir+rtl
rtl/rhct_pkg.sv
rtl/rhct_cordic.sv
rtl/rhct_satdiv.sv
rtl/rhct_hue.sv
rtl/rgb_to_hsi_color_threshold.sv
tb/tb_rgb_to_hsi_color_threshold.sv
